@@ rtl/corner_turn_writer_with_watermarks_defines.svh @@
// Assertion macros shared by the corner-turn writer RTL.
`ifndef CORNER_TURN_WRITER_WITH_WATERMARKS_DEFINES_SVH
`define CORNER_TURN_WRITER_WITH_WATERMARKS_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define CTW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle implies a property in the next cycle.
`define CTW_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/ctw_pkg.sv @@
// Package with constants, codes and shared types of the corner-turn writer.
`default_nettype none

package ctw_pkg;

   localparam int MAX_ANTENNAS = 256;
   localparam int NUM_BUFFERS  = 2;
   localparam int TIME_BLOCK   = 16;
   localparam int NUM_POLS     = 2;
   localparam int BLOCK_SHIFT  = 4;

   localparam int OP_W   = 2;
   localparam int ANT_W  = 8;
   localparam int CNT_W  = 9;
   localparam int SMP_W  = 20;
   localparam int SCNT_W = 21;
   localparam int DATA_W = 16;
   localparam int ADDR_W = 32;
   localparam int WM_W   = 17;
   localparam int BLK_W  = 16;
   localparam int TIME_W = 4;
   localparam int KIND_W = 2;

   localparam int MEM_DEPTH = NUM_BUFFERS * MAX_ANTENNAS;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_DATA    = 2'd0,
      OP_RELEASE = 2'd1,
      OP_QUERY   = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_QUERY   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      WM_RAISE,
      WM_RELEASE,
      WM_QUERY
   } wm_op_type;

   // Command to the watermark unit: sweep antennas first .. stop-1 of one buffer.
   typedef struct packed {
      logic             start;
      wm_op_type        op;
      logic             buf_sel;
      logic [ANT_W-1:0] first;
      logic [CNT_W-1:0] stop;
      logic [WM_W-1:0]  level;
   } wm_cmd_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [WM_W-1:0] result;
   } wm_stat_type;

endpackage

`default_nettype wire

@@ rtl/ctw_if.sv @@
// Valid/ready channel interfaces for the request and response streams.
`default_nettype none

interface ctw_req_if import ctw_pkg::*;;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic              buffer_index;
   logic [ANT_W-1:0]  first_antenna;
   logic [CNT_W-1:0]  antenna_count;
   logic [SMP_W-1:0]  start_sample;
   logic [SCNT_W-1:0] sample_count;
   logic [DATA_W-1:0] element;
   logic              last;

   modport source (
      output valid, op, buffer_index, first_antenna, antenna_count,
             start_sample, sample_count, element, last,
      input  ready
   );
   modport sink (
      input  valid, op, buffer_index, first_antenna, antenna_count,
             start_sample, sample_count, element, last,
      output ready
   );
endinterface

interface ctw_rsp_if import ctw_pkg::*;;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic              write_buffer;
   logic [ADDR_W-1:0] write_address;
   logic [DATA_W-1:0] write_data;
   logic [WM_W-1:0]   safe_block;

   modport source (
      output valid, kind, write_buffer, write_address, write_data, safe_block,
      input  ready
   );
   modport sink (
      input  valid, kind, write_buffer, write_address, write_data, safe_block,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/ctw_wm_unit.sv @@
// Watermark store with its sweep sequencer and shared compare unit.
`default_nettype none

module ctw_wm_unit import ctw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  wm_cmd_type  cmd,
   output wm_stat_type stat
);

   typedef enum logic [1:0] {
      W_CLEAR,
      W_IDLE,
      W_RUN
   } wstate_type;

   wstate_type        state_ff, state_in;
   logic [MEM_AW-1:0] clr_ff, clr_in;
   wm_op_type         op_ff, op_in;
   logic              sel_ff, sel_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  stop_ff, stop_in;
   logic [WM_W-1:0]   level_ff, level_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [ANT_W-1:0]  rd_addr_ff, rd_addr_in;
   logic              first_ff, first_in;
   logic [WM_W-1:0]   mn_ff, mn_in;
   logic              done_ff, done_in;

   logic [WM_W-1:0]   mem [MEM_DEPTH];
   logic [WM_W-1:0]   rdata_ff;

   logic              issue;
   logic              mem_re;
   logic [MEM_AW-1:0] mem_raddr;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [WM_W-1:0]   mem_wdata;
   logic [WM_W-1:0]   cmp_b;
   logic              lower;

   assign issue     = (state_ff == W_RUN) && (ptr_ff < stop_ff);
   assign mem_re    = issue && (op_ff != WM_RELEASE);
   assign mem_raddr = {sel_ff, ptr_ff[ANT_W-1:0]};

   // One comparator serves both the raise (level above stored) and the minimum search.
   assign cmp_b = (op_ff == WM_QUERY) ? mn_ff : level_ff;
   assign lower = rdata_ff < cmp_b;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      if (state_ff == W_CLEAR) begin
         mem_we = 1'b1;
      end else if (issue && (op_ff == WM_RELEASE)) begin
         mem_we    = 1'b1;
         mem_waddr = {sel_ff, ptr_ff[ANT_W-1:0]};
      end else if (rd_vld_ff && (op_ff == WM_RAISE) && lower) begin
         mem_we    = 1'b1;
         mem_waddr = {sel_ff, rd_addr_ff};
         mem_wdata = level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      op_in      = op_ff;
      sel_in     = sel_ff;
      ptr_in     = ptr_ff;
      stop_in    = stop_ff;
      level_in   = level_ff;
      first_in   = first_ff;
      mn_in      = mn_ff;
      done_in    = 1'b0;
      rd_vld_in  = mem_re;
      rd_addr_in = ptr_ff[ANT_W-1:0];
      unique case (state_ff)
         W_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = W_IDLE;
            end
         end
         W_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               sel_in   = cmd.buf_sel;
               ptr_in   = {1'b0, cmd.first};
               stop_in  = cmd.stop;
               level_in = cmd.level;
               first_in = 1'b1;
               state_in = W_RUN;
            end
         end
         W_RUN: begin
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (rd_vld_ff && (op_ff == WM_QUERY)) begin
               if (first_ff || lower) begin
                  mn_in = rdata_ff;
               end
               first_in = 1'b0;
            end
            if (!issue && !rd_vld_ff) begin
               done_in  = 1'b1;
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= W_CLEAR;
         clr_ff    <= '0;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         rd_vld_ff <= rd_vld_in;
         done_ff   <= done_in;
      end
      op_ff      <= op_in;
      sel_ff     <= sel_in;
      ptr_ff     <= ptr_in;
      stop_ff    <= stop_in;
      level_ff   <= level_in;
      rd_addr_ff <= rd_addr_in;
      first_ff   <= first_in;
      mn_ff      <= mn_in;
   end

   assign stat.busy   = (state_ff != W_IDLE);
   assign stat.done   = done_ff;
   assign stat.result = mn_ff;

endmodule

`default_nettype wire

@@ rtl/corner_turn_writer_with_watermarks.sv @@
// Top level of the corner-turn writer: address path, packet counters and sequencer.
//
// Requests arrive on req_bus (valid/ready). A data element gives one write
// response with buffer, element address in [block][antenna][pol][time] order
// and the sample, unless it lies past the whole 16-sample blocks of its packet.
// A release and a query each give one response on rsp_bus.
// csr_write_enable/csr_write_data set the antennas in use; the user writes them
// only while the block idles, as the block itself does not enforce this.
// A data element passes the address multiply and add stages before its response
// is registered; the next request is taken once the sequencer is back in idle.
// The last element of a packet then sweeps the watermark memory over the
// covered antennas, one entry a cycle.
// A query sweeps the antennas in use; a release writes all 256 entries of its buffer.
// After reset a clearing pass over all 512 entries zeroes all watermarks, with
// req_bus.ready low throughout. A response waits in an output register while
// the receiver stalls; the next request is still taken, and the sequencer only
// holds when it has a new response and the register is still full.
`default_nettype none
`include "corner_turn_writer_with_watermarks_defines.svh"

module corner_turn_writer_with_watermarks import ctw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ctw_req_if.sink          req_bus,
   ctw_rsp_if.source        rsp_bus,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_WM,
      S_EMIT
   } state_type;

   localparam int MB_W     = BLK_W + 1;
   localparam int STRIDE_W = CNT_W + $clog2(NUM_POLS * TIME_BLOCK);
   localparam int PROD_W   = MB_W + STRIDE_W;
   localparam int ROW_SH   = $clog2(NUM_POLS * TIME_BLOCK);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  antennas_ff;
   logic              pol_cnt_ff, pol_cnt_in;
   logic [ANT_W-1:0]  ant_cnt_ff, ant_cnt_in;
   logic [TIME_W-1:0] time_cnt_ff, time_cnt_in;
   logic [BLK_W-1:0]  blk_cnt_ff, blk_cnt_in;

   logic [MB_W-1:0]   m_ff, m_in;
   logic [CNT_W-1:0]  r_ff, r_in;
   logic              pol_ff, pol_in;
   logic [TIME_W-1:0] t_ff, t_in;
   logic [DATA_W-1:0] elem_ff, elem_in;
   logic              wbuf_ff, wbuf_in;
   logic              emit_ff, emit_in;
   logic              last_ff, last_in;
   logic [WM_W-1:0]   level_ff, level_in;
   logic [ANT_W-1:0]  first_ff, first_in;
   logic [CNT_W-1:0]  stop_ff, stop_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   wm_cmd_type        cmd_ff, cmd_in;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic              rsp_buf_ff, rsp_buf_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [WM_W-1:0]   rsp_safe_ff, rsp_safe_in;

   wm_stat_type       wm_stat;

   logic                  accept;
   logic                  slot_free;
   logic [CNT_W-1:0]      ant_eff;
   logic [STRIDE_W-1:0]   stride;
   logic [MB_W-1:0]       blocks;
   logic [BLK_W-1:0]      m0;
   logic [WM_W-1:0]       final_sum;
   logic [CNT_W:0]        span_end;
   logic [ADDR_W-1:0]     address;

   ctw_wm_unit u_wm (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .stat  (wm_stat)
   );

   assign req_bus.ready = (state_ff == S_IDLE) && !wm_stat.busy;
   assign accept        = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   // Out-of-range antenna settings are clamped to 1 .. MAX_ANTENNAS.
   always_comb begin
      ant_eff = antennas_ff;
      if (antennas_ff == '0) begin
         ant_eff = CNT_W'(1);
      end else if (antennas_ff > CNT_W'(MAX_ANTENNAS)) begin
         ant_eff = CNT_W'(MAX_ANTENNAS);
      end
   end

   assign stride    = {ant_eff, ROW_SH'(0)};
   assign blocks    = req_bus.sample_count[SCNT_W-1:BLOCK_SHIFT];
   assign m0        = req_bus.start_sample[SMP_W-1:BLOCK_SHIFT];
   // The final block index is kept to the watermark width.
   assign final_sum = {1'b0, m0} + blocks;
   assign span_end  = {2'b00, req_bus.first_antenna} + {1'b0, req_bus.antenna_count};
   assign address   = ADDR_W'(prod_ff) + ADDR_W'({r_ff, ROW_SH'(0)}) + ADDR_W'({pol_ff, t_ff});

   always_comb begin
      state_in     = state_ff;
      pol_cnt_in   = pol_cnt_ff;
      ant_cnt_in   = ant_cnt_ff;
      time_cnt_in  = time_cnt_ff;
      blk_cnt_in   = blk_cnt_ff;
      m_in         = m_ff;
      r_in         = r_ff;
      pol_in       = pol_ff;
      t_in         = t_ff;
      elem_in      = elem_ff;
      wbuf_in      = wbuf_ff;
      emit_in      = emit_ff;
      last_in      = last_ff;
      level_in     = level_ff;
      first_in     = first_ff;
      stop_in      = stop_ff;
      prod_in      = prod_ff;
      cmd_in       = cmd_ff;
      cmd_in.start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_buf_in   = rsp_buf_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_safe_in  = rsp_safe_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_bus.op)
                  OP_DATA: begin
                     m_in     = {1'b0, m0} + {1'b0, blk_cnt_ff};
                     r_in     = {1'b0, req_bus.first_antenna} + {1'b0, ant_cnt_ff};
                     pol_in   = pol_cnt_ff;
                     t_in     = time_cnt_ff;
                     elem_in  = req_bus.element;
                     wbuf_in  = req_bus.buffer_index;
                     emit_in  = {1'b0, blk_cnt_ff} < blocks;
                     last_in  = req_bus.last;
                     level_in = final_sum;
                     first_in = req_bus.first_antenna;
                     stop_in  = (span_end > (CNT_W+1)'(MAX_ANTENNAS)) ?
                                CNT_W'(MAX_ANTENNAS) : span_end[CNT_W-1:0];
                     // Position counters run pol, then antenna, then time, then block.
                     if (req_bus.last) begin
                        pol_cnt_in  = 1'b0;
                        ant_cnt_in  = '0;
                        time_cnt_in = '0;
                        blk_cnt_in  = '0;
                     end else if (!pol_cnt_ff) begin
                        pol_cnt_in = 1'b1;
                     end else begin
                        pol_cnt_in = 1'b0;
                        if ({1'b0, ant_cnt_ff} + 1'b1 < req_bus.antenna_count) begin
                           ant_cnt_in = ant_cnt_ff + 1'b1;
                        end else begin
                           ant_cnt_in = '0;
                           time_cnt_in = time_cnt_ff + 1'b1;
                           if (&time_cnt_ff) begin
                              if (!(&blk_cnt_ff)) begin
                                 blk_cnt_in = blk_cnt_ff + 1'b1;
                              end
                           end
                        end
                     end
                     state_in = S_MUL;
                  end
                  OP_RELEASE: begin
                     cmd_in.start   = 1'b1;
                     cmd_in.op      = WM_RELEASE;
                     cmd_in.buf_sel = req_bus.buffer_index;
                     cmd_in.first   = '0;
                     cmd_in.stop    = CNT_W'(MAX_ANTENNAS);
                     state_in       = S_WM;
                  end
                  OP_QUERY: begin
                     cmd_in.start   = 1'b1;
                     cmd_in.op      = WM_QUERY;
                     cmd_in.buf_sel = req_bus.buffer_index;
                     cmd_in.first   = '0;
                     cmd_in.stop    = ant_eff;
                     state_in       = S_WM;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(m_ff) * PROD_W'(stride);
            state_in = S_ADD;
         end
         S_ADD: begin
            if (!emit_ff || slot_free) begin
               if (emit_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_WRITE;
                  rsp_buf_in   = wbuf_ff;
                  rsp_addr_in  = address;
                  rsp_data_in  = elem_ff;
                  rsp_safe_in  = '0;
               end
               if (last_ff) begin
                  cmd_in.start   = 1'b1;
                  cmd_in.op      = WM_RAISE;
                  cmd_in.buf_sel = wbuf_ff;
                  cmd_in.first   = first_ff;
                  cmd_in.stop    = stop_ff;
                  cmd_in.level   = level_ff;
                  state_in       = S_WM;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_WM: begin
            if (wm_stat.done) begin
               state_in = (cmd_ff.op == WM_RAISE) ? S_IDLE : S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_buf_in   = 1'b0;
               rsp_addr_in  = '0;
               rsp_data_in  = '0;
               if (cmd_ff.op == WM_QUERY) begin
                  rsp_kind_in = KIND_QUERY;
                  rsp_safe_in = wm_stat.result;
               end else begin
                  rsp_kind_in = KIND_RELEASE;
                  rsp_safe_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         antennas_ff  <= CNT_W'(MAX_ANTENNAS);
         pol_cnt_ff   <= 1'b0;
         ant_cnt_ff   <= '0;
         time_cnt_ff  <= '0;
         blk_cnt_ff   <= '0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            antennas_ff <= csr_write_data;
         end
         pol_cnt_ff   <= pol_cnt_in;
         ant_cnt_ff   <= ant_cnt_in;
         time_cnt_ff  <= time_cnt_in;
         blk_cnt_ff   <= blk_cnt_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff        <= m_in;
      r_ff        <= r_in;
      pol_ff      <= pol_in;
      t_ff        <= t_in;
      elem_ff     <= elem_in;
      wbuf_ff     <= wbuf_in;
      emit_ff     <= emit_in;
      last_ff     <= last_in;
      level_ff    <= level_in;
      first_ff    <= first_in;
      stop_ff     <= stop_in;
      prod_ff     <= prod_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_buf_ff  <= rsp_buf_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_safe_ff <= rsp_safe_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_kind_ff;
   assign rsp_bus.write_buffer  = rsp_buf_ff;
   assign rsp_bus.write_address = rsp_addr_ff;
   assign rsp_bus.write_data    = rsp_data_ff;
   assign rsp_bus.safe_block    = rsp_safe_ff;

   `CTW_ASSERT(a_done_while_waiting, wm_stat.done |-> (state_ff == S_WM), "watermark sweep ended outside wait state")
   `CTW_ASSERT(a_start_when_free, cmd_ff.start |-> !wm_stat.busy, "watermark command issued while unit busy")
   `CTW_ASSERT_NEXT(a_data_to_multiply, accept && (req_bus.op == OP_DATA), state_ff == S_MUL, "data transfer did not enter the multiply step")

endmodule

`default_nettype wire
